@@ rtl/glr_pkg.sv @@
// Package for the gradient line rasterizer: widths, stream field offsets,
// constants and the command/status structs between controller and datapath.
// No dependencies.
package glr_pkg;

    // Coordinate width of every x/y field.
    localparam int COORD_BITS  = 12;
    localparam int COLOR_BITS  = 24;
    localparam int SCR_BITS    = 11;
    localparam int ERR_BITS    = COORD_BITS + 2;
    // Quotient of remaining*100/span never exceeds 100.
    localparam int Q_BITS      = 7;
    localparam int Q_CNT_BITS  = $clog2(Q_BITS);
    localparam int DVD_BITS    = COORD_BITS + Q_BITS;
    localparam int CMP_BITS    = (COORD_BITS > SCR_BITS) ? COORD_BITS : SCR_BITS;

    localparam logic [SCR_BITS-1:0] SCR_RESET = SCR_BITS'(1000);
    localparam logic [Q_BITS-1:0]   PCT_FULL  = Q_BITS'(100);

    // floor(a/100) == (a*5243) >> 19 for a below 43699
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Stream packing, first field in the lowest bits.
    localparam int S_FROM_X_LSB     = 0;
    localparam int S_FROM_Y_LSB     = COORD_BITS;
    localparam int S_TO_X_LSB       = 2 * COORD_BITS;
    localparam int S_TO_Y_LSB       = 3 * COORD_BITS;
    localparam int S_FROM_COLOR_LSB = 4 * COORD_BITS;
    localparam int S_TO_COLOR_LSB   = 4 * COORD_BITS + COLOR_BITS;
    localparam int S_TDATA_BITS     = ((4 * COORD_BITS + 2 * COLOR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS     = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    // Input kinds carried on s_tuser.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic load;     // latch a new line
        logic step;     // capture pixel, advance walk, start divider
        logic finish;   // capture end point pixel, close the line
        logic mul;      // byte difference times percent
        logic scale;    // divide products by 100
        logic emit;     // write the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic active;   // a line is loaded and not finished
        logic at_end;   // major coordinate reached its end
        logic div_done;
        logic out_free; // output register can take a result
    } dp_status_t;

endpackage

@@ rtl/gradient_line_rasterizer_top.sv @@
// Gradient line rasterizer, top level: Bresenham line walk with a per-pixel
// color blend. Depends on glr_pkg, glr_ctrl, glr_dp (and glr_div below it).
//
// Usage:
//  - s_ channel: one item per transfer, s_tuser = mode (0 load a line, 1 step
//    to the next pixel). A load returns nothing and leaves s_tready high; a
//    step while no line is loaded is dropped.
//  - m_ channel: one pixel per step transfer; tdata = x, y, color; tuser =
//    on-screen flag; tlast marks the end point pixel, which closes the line.
//  - cfg channel writes screen_width (index 0) and screen_height (index 1);
//    cfg_ready is always high. Write only while the block is idle.
// Timing:
//  - Ordinary step: after the transfer the bit-serial divider forms
//    remaining*100/span (7 quotient bits, one per cycle, then the done
//    check), then come a multiply, a divide-by-100 and the output write.
//    End point step: the end point pixel goes straight to the output write.
//  - s_tready is low while a step is in work, so a step is taken only once
//    the last is through. A stalled receiver holds the finished pixel in the
//    datapath and keeps s_tready low until the output register frees up.
// Reset (aresetn low, synchronous): no line loaded, output empty, screen
// size 1000 x 1000.
module gradient_line_rasterizer_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // from_x, from_y, to_x, to_y, from_color, to_color (low to high)
    input  logic [glr_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // mode
    input  logic                                 s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pixel_x, pixel_y, pixel_color (low to high), zero fill above
    output logic [glr_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // on_screen
    output logic                                 m_tuser,
    // last_pixel
    output logic                                 m_tlast,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [glr_pkg::SCR_BITS-1:0]         cfg_data
);

    glr_pkg::ctrl_cmd_t  cmd;
    glr_pkg::dp_status_t status;

    // register writes are never held off
    assign cfg_ready = 1'b1;

    glr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    glr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ rtl/glr_div.sv @@
// Restoring divider, one quotient bit per cycle, for remaining*100/span.
// Depends on glr_pkg.
module glr_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [glr_pkg::DVD_BITS-1:0]       dividend,
    input  logic [glr_pkg::COORD_BITS-1:0]     divisor,
    output logic [glr_pkg::Q_BITS-1:0]         quotient,
    output logic                               done
);

    localparam int DB = glr_pkg::DVD_BITS;

    logic [DB-1:0]                     rem_reg, rem_next;
    logic [DB-2:0]                     dvs_reg, dvs_next;
    logic [glr_pkg::Q_BITS-1:0]        q_reg, q_next;
    logic [glr_pkg::Q_CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                              run_reg, run_next;
    logic [DB:0]                       trial;
    logic                              fits;

    assign trial = {1'b0, rem_reg} - {2'b00, dvs_reg};
    assign fits  = ~trial[DB];

    always_comb begin
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (start) begin
            rem_next = dividend;
            dvs_next = (DB - 1)'(divisor) << (glr_pkg::Q_BITS - 1);
            q_next   = '0;
            cnt_next = glr_pkg::Q_CNT_BITS'(glr_pkg::Q_BITS - 1);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (fits) begin
                rem_next = trial[DB-1:0];
            end
            dvs_next = dvs_reg >> 1;
            q_next   = {q_reg[glr_pkg::Q_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign quotient = q_reg;
    assign done     = ~run_reg;

endmodule

@@ rtl/glr_dp.sv @@
// Datapath: line walk registers, screen registers, color blend lanes and
// output register. Depends on glr_pkg and glr_div.
module glr_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  glr_pkg::ctrl_cmd_t                   cmd,
    output glr_pkg::dp_status_t                  status,
    input  logic [glr_pkg::S_TDATA_BITS-1:0]     s_tdata,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_index,
    input  logic [glr_pkg::SCR_BITS-1:0]         cfg_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [glr_pkg::M_TDATA_BITS-1:0]     m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int C  = glr_pkg::COORD_BITS;
    localparam int EB = glr_pkg::ERR_BITS;

    // unpacked input fields
    logic signed [C-1:0] in_from_x, in_from_y, in_to_x, in_to_y;
    logic [23:0]         in_from_color, in_to_color;

    assign in_from_x     = s_tdata[glr_pkg::S_FROM_X_LSB +: C];
    assign in_from_y     = s_tdata[glr_pkg::S_FROM_Y_LSB +: C];
    assign in_to_x       = s_tdata[glr_pkg::S_TO_X_LSB +: C];
    assign in_to_y       = s_tdata[glr_pkg::S_TO_Y_LSB +: C];
    assign in_from_color = s_tdata[glr_pkg::S_FROM_COLOR_LSB +: 24];
    assign in_to_color   = s_tdata[glr_pkg::S_TO_COLOR_LSB +: 24];

    // walk state
    logic signed [C-1:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [C-1:0]  end_x_reg, end_x_next, end_y_reg, end_y_next;
    logic signed [1:0]    step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic [C-1:0]         span_x_reg, span_x_next, span_y_reg, span_y_next;
    logic signed [EB-1:0] err_reg, err_next;
    logic                 x_major_reg, x_major_next;
    logic [23:0]          color_a_reg, color_a_next, color_b_reg, color_b_next;
    logic [23:0]          shade_reg, shade_next;
    logic                 active_reg, active_next;
    logic [glr_pkg::SCR_BITS-1:0] scr_w_reg, scr_w_next, scr_h_reg, scr_h_next;

    // captured pixel
    logic signed [C-1:0]  pix_x_reg, pix_x_next, pix_y_reg, pix_y_next;
    logic                 pix_on_reg, pix_on_next, pix_last_reg, pix_last_next;

    // blend lanes
    logic signed [15:0]   prod_reg [3];
    logic signed [15:0]   prod_next [3];
    logic [7:0]           qmag_reg [3];
    logic [7:0]           qmag_next [3];
    logic                 neg_reg [3];
    logic                 neg_next [3];

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic signed [C-1:0]  out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [23:0]          out_color_reg, out_color_next;
    logic                 out_on_reg, out_on_next, out_last_reg, out_last_next;

    // load setup
    logic signed [C:0]    ld_dx, ld_dy;
    logic [C-1:0]         ld_span_x, ld_span_y;

    assign ld_dx     = (C + 1)'(in_to_x) - (C + 1)'(in_from_x);
    assign ld_dy     = (C + 1)'(in_to_y) - (C + 1)'(in_from_y);
    assign ld_span_x = ld_dx[C] ? C'(-ld_dx) : ld_dx[C-1:0];
    assign ld_span_y = ld_dy[C] ? C'(-ld_dy) : ld_dy[C-1:0];

    function automatic logic signed [1:0] sign_of(input logic signed [C:0] d);
        logic signed [1:0] s;
        if (d == '0) begin
            s = 2'sd0;
        end else if (d[C]) begin
            s = -2'sd1;
        end else begin
            s = 2'sd1;
        end
        return s;
    endfunction

    function automatic logic on_screen_f(input logic signed [C-1:0] px,
                                         input logic signed [C-1:0] py,
                                         input logic [glr_pkg::SCR_BITS-1:0] w,
                                         input logic [glr_pkg::SCR_BITS-1:0] h);
        logic in_x, in_y;
        in_x = ~px[C-1] &&
               (glr_pkg::CMP_BITS'(unsigned'(px)) < glr_pkg::CMP_BITS'(w));
        in_y = ~py[C-1] &&
               (glr_pkg::CMP_BITS'(unsigned'(py)) < glr_pkg::CMP_BITS'(h));
        return in_x && in_y;
    endfunction

    // running walk terms
    logic signed [C:0]    run_dx, run_dy;
    logic [C-1:0]         rem_x, rem_y, maj_rem, maj_span, min_span;
    logic signed [EB-1:0] err_sum;
    logic                 minor_move;
    logic signed [C-1:0]  adv_x, adv_y;
    logic                 at_end;

    assign run_dx   = (C + 1)'(end_x_reg) - (C + 1)'(cur_x_reg);
    assign run_dy   = (C + 1)'(end_y_reg) - (C + 1)'(cur_y_reg);
    assign rem_x    = run_dx[C] ? C'(-run_dx) : run_dx[C-1:0];
    assign rem_y    = run_dy[C] ? C'(-run_dy) : run_dy[C-1:0];
    assign maj_rem  = x_major_reg ? rem_x : rem_y;
    assign maj_span = x_major_reg ? span_x_reg : span_y_reg;
    assign min_span = x_major_reg ? span_y_reg : span_x_reg;
    assign at_end   = x_major_reg ? (cur_x_reg == end_x_reg) : (cur_y_reg == end_y_reg);
    assign err_sum  = err_reg + $signed({2'b00, min_span});
    // 2*err >= major span
    assign minor_move = $signed({err_sum, 1'b0}) >= $signed({3'b000, maj_span});
    assign adv_x    = cur_x_reg + C'(step_x_reg);
    assign adv_y    = cur_y_reg + C'(step_y_reg);

    // divider
    logic [glr_pkg::DVD_BITS-1:0] dividend;
    logic [glr_pkg::Q_BITS-1:0]   quotient;
    logic                         div_done;
    logic [glr_pkg::Q_BITS-1:0]   pct;

    assign dividend = glr_pkg::DVD_BITS'(maj_rem) * glr_pkg::DVD_BITS'(100);
    assign pct      = glr_pkg::PCT_FULL - quotient;

    glr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.step),
        .dividend (dividend),
        .divisor  (maj_span),
        .quotient (quotient),
        .done     (div_done)
    );

    // per byte lane arithmetic
    logic signed [8:0]  lane_diff [3];
    logic signed [16:0] lane_prod [3];
    logic [14:0]        lane_mag [3];
    logic [27:0]        lane_scaled [3];
    logic [7:0]         lane_byte [3];
    logic [23:0]        blend_color;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lane_diff[k]   = $signed({1'b0, color_b_reg[8*k +: 8]})
                           - $signed({1'b0, color_a_reg[8*k +: 8]});
            lane_prod[k]   = lane_diff[k] * $signed({1'b0, pct});
            lane_mag[k]    = prod_reg[k][15] ? 15'(-prod_reg[k]) : prod_reg[k][14:0];
            lane_scaled[k] = 28'(lane_mag[k]) * 28'(glr_pkg::RECIP_100);
            // truncation toward zero: magnitude quotient, sign restored
            lane_byte[k]   = neg_reg[k] ? color_a_reg[8*k +: 8] - qmag_reg[k]
                                        : color_a_reg[8*k +: 8] + qmag_reg[k];
        end
    end

    assign blend_color = {lane_byte[2], lane_byte[1], lane_byte[0]};

    always_comb begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        err_next       = err_reg;
        x_major_next   = x_major_reg;
        color_a_next   = color_a_reg;
        color_b_next   = color_b_reg;
        shade_next     = shade_reg;
        active_next    = active_reg;
        scr_w_next     = scr_w_reg;
        scr_h_next     = scr_h_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        pix_on_next    = pix_on_reg;
        pix_last_next  = pix_last_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_on_next    = out_on_reg;
        out_last_next  = out_last_reg;
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = prod_reg[k];
            qmag_next[k] = qmag_reg[k];
            neg_next[k]  = neg_reg[k];
        end

        if (cmd.load) begin
            cur_x_next   = in_from_x;
            cur_y_next   = in_from_y;
            end_x_next   = in_to_x;
            end_y_next   = in_to_y;
            step_x_next  = sign_of(ld_dx);
            step_y_next  = sign_of(ld_dy);
            span_x_next  = ld_span_x;
            span_y_next  = ld_span_y;
            x_major_next = ld_span_x >= ld_span_y;
            err_next     = '0;
            color_a_next = in_from_color;
            color_b_next = in_to_color;
            shade_next   = in_from_color;
            active_next  = 1'b1;
        end

        if (cmd.step) begin
            pix_x_next    = cur_x_reg;
            pix_y_next    = cur_y_reg;
            pix_on_next   = on_screen_f(cur_x_reg, cur_y_reg, scr_w_reg, scr_h_reg);
            pix_last_next = 1'b0;
            err_next      = minor_move ? err_sum - $signed({2'b00, maj_span}) : err_sum;
            if (x_major_reg) begin
                cur_x_next = adv_x;
                if (minor_move) begin
                    cur_y_next = adv_y;
                end
            end else begin
                cur_y_next = adv_y;
                if (minor_move) begin
                    cur_x_next = adv_x;
                end
            end
        end

        if (cmd.finish) begin
            pix_x_next    = end_x_reg;
            pix_y_next    = end_y_reg;
            pix_on_next   = on_screen_f(end_x_reg, end_y_reg, scr_w_reg, scr_h_reg);
            pix_last_next = 1'b1;
            active_next   = 1'b0;
        end

        if (cmd.mul) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[k] = lane_prod[k][15:0];
            end
        end

        if (cmd.scale) begin
            for (int k = 0; k < 3; k++) begin
                qmag_next[k] = lane_scaled[k][glr_pkg::RECIP_SHIFT +: 8];
                neg_next[k]  = prod_reg[k][15];
            end
        end

        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_x_next     = pix_x_reg;
            out_y_next     = pix_y_reg;
            out_on_next    = pix_on_reg;
            out_last_next  = pix_last_reg;
            // end point pixel repeats the previous color
            out_color_next = pix_last_reg ? shade_reg : blend_color;
            if (!pix_last_reg) begin
                shade_next = blend_color;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            if (cfg_index) begin
                scr_h_next = cfg_data;
            end else begin
                scr_w_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            scr_w_reg     <= glr_pkg::SCR_RESET;
            scr_h_reg     <= glr_pkg::SCR_RESET;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            scr_w_reg     <= scr_w_next;
            scr_h_reg     <= scr_h_next;
        end
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        end_x_reg     <= end_x_next;
        end_y_reg     <= end_y_next;
        step_x_reg    <= step_x_next;
        step_y_reg    <= step_y_next;
        span_x_reg    <= span_x_next;
        span_y_reg    <= span_y_next;
        err_reg       <= err_next;
        x_major_reg   <= x_major_next;
        color_a_reg   <= color_a_next;
        color_b_reg   <= color_b_next;
        shade_reg     <= shade_next;
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        pix_on_reg    <= pix_on_next;
        pix_last_reg  <= pix_last_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_on_reg    <= out_on_next;
        out_last_reg  <= out_last_next;
        for (int k = 0; k < 3; k++) begin
            prod_reg[k] <= prod_next[k];
            qmag_reg[k] <= qmag_next[k];
            neg_reg[k]  <= neg_next[k];
        end
    end

    assign status.active   = active_reg;
    assign status.at_end   = at_end;
    assign status.div_done = div_done;
    assign status.out_free = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = glr_pkg::M_TDATA_BITS'({out_color_reg, out_y_reg, out_x_reg});
    assign m_tuser  = out_on_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/glr_ctrl.sv @@
// Controller state machine: sequences load, pixel walk, divide, blend and
// output write. Depends on glr_pkg.
module glr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    input  glr_pkg::dp_status_t  status,
    output glr_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == glr_pkg::MODE_LOAD) begin
                        cmd.load = 1'b1;
                    end else if (status.active) begin
                        if (status.at_end) begin
                            cmd.finish = 1'b1;
                            state_next = ST_EMIT;
                        end else begin
                            cmd.step   = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ dv/tb_gradient_line_rasterizer_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gradient_line_rasterizer_top: drives line loads and pixel steps,
// predicts every pixel (walk, gradient, screen flag, end mark) and checks the result stream.
// Depends on glr_pkg and the RTL under rtl/.
module tb_gradient_line_rasterizer_top;

    import glr_pkg::*;

    localparam int CW = glr_pkg::COORD_BITS;
    localparam int NUM_PHASES = 7;
    localparam int PHASE_ITEMS = 180;
    localparam int DRAIN_CYCLES = 16;   // covers the latency of an ordinary step

    // configuration register indexes
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef struct {
        logic                  mode;
        logic signed [CW-1:0]  from_x;
        logic signed [CW-1:0]  from_y;
        logic signed [CW-1:0]  to_x;
        logic signed [CW-1:0]  to_y;
        logic [COLOR_BITS-1:0] from_color;
        logic [COLOR_BITS-1:0] to_color;
    } line_cmd_t;

    typedef struct {
        logic [CW-1:0]         x;
        logic [CW-1:0]         y;
        logic [COLOR_BITS-1:0] color;
        logic                  on_screen;
        logic                  last;
    } pixel_t;

    // ---------------------------------------------------------------- DUT ports
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;
    logic                    s_tuser   = MODE_STEP;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic                    cfg_index = REG_SCREEN_WIDTH;
    logic [SCR_BITS-1:0]     cfg_data  = '0;

    gradient_line_rasterizer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- shared state
    line_cmd_t line_cmds[$];     // items waiting for the driver
    pixel_t    pixels_due[$];    // predicted pixels, oldest first
    line_cmd_t cmd_on_bus;       // item currently offered on s_
    int        mismatches = 0;
    bit        no_idle = 1'b0;   // final stretch runs both sides at full rate

    // predictor copy of the screen registers and the line walker
    int   scr_w = 1000;
    int   scr_h = 1000;
    int   ln_cur_x, ln_cur_y, ln_end_x, ln_end_y;
    int   ln_step_x, ln_step_y, ln_span_x, ln_span_y, ln_err;
    bit   ln_x_major;
    bit   ln_busy = 1'b0;
    logic [COLOR_BITS-1:0] ln_color_a, ln_color_b, ln_shade;

    // ---------------------------------------------------------------- predictor
    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int isign(int v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // percent along the major axis, then a truncating signed blend per byte
    function automatic logic [COLOR_BITS-1:0] blend_color(int remaining, int span);
        int pct, b1, b2, v;
        logic [COLOR_BITS-1:0] c;
        pct = (span > 0) ? 100 - (remaining * 100) / span : 100;
        c = '0;
        for (int k = 0; k < 3; k++) begin
            b1 = int'(ln_color_a[8*k +: 8]);
            b2 = int'(ln_color_b[8*k +: 8]);
            v = ((b2 - b1) * pct) / 100 + b1;
            c[8*k +: 8] = v[7:0];
        end
        return c;
    endfunction

    function automatic pixel_t make_pixel(int x, int y, logic [COLOR_BITS-1:0] c, logic last);
        pixel_t p;
        p.x = CW'(x);
        p.y = CW'(y);
        p.color = c;
        p.on_screen = (x >= 0 && y >= 0 && x < scr_w && y < scr_h);
        p.last = last;
        return p;
    endfunction

    // advances the walker by one accepted item; returns 1 when a pixel comes out
    function automatic bit walk_pixel(input line_cmd_t cmd, output pixel_t px);
        px = make_pixel(0, 0, '0, 1'b0);
        if (cmd.mode == MODE_LOAD) begin
            ln_cur_x   = int'(cmd.from_x);
            ln_cur_y   = int'(cmd.from_y);
            ln_end_x   = int'(cmd.to_x);
            ln_end_y   = int'(cmd.to_y);
            ln_color_a = cmd.from_color;
            ln_color_b = cmd.to_color;
            ln_step_x  = isign(ln_end_x - ln_cur_x);
            ln_step_y  = isign(ln_end_y - ln_cur_y);
            ln_span_x  = iabs(ln_end_x - ln_cur_x);
            ln_span_y  = iabs(ln_end_y - ln_cur_y);
            ln_x_major = (ln_span_x >= ln_span_y);
            ln_err     = 0;
            ln_shade   = cmd.from_color;   // zero-length line ends in the start color
            ln_busy    = 1'b1;
            return 1'b0;
        end
        if (!ln_busy)
            return 1'b0;                   // step with no line loaded is dropped
        if (ln_x_major ? (ln_cur_x != ln_end_x) : (ln_cur_y != ln_end_y)) begin
            if (ln_x_major) begin
                ln_shade = blend_color(iabs(ln_end_x - ln_cur_x), ln_span_x);
                px = make_pixel(ln_cur_x, ln_cur_y, ln_shade, 1'b0);
                ln_err += ln_span_y;
                if (2 * ln_err >= ln_span_x) begin
                    ln_cur_y += ln_step_y;
                    ln_err   -= ln_span_x;
                end
                ln_cur_x += ln_step_x;
            end else begin
                ln_shade = blend_color(iabs(ln_end_y - ln_cur_y), ln_span_y);
                px = make_pixel(ln_cur_x, ln_cur_y, ln_shade, 1'b0);
                ln_err += ln_span_x;
                if (2 * ln_err >= ln_span_y) begin
                    ln_cur_x += ln_step_x;
                    ln_err   -= ln_span_y;
                end
                ln_cur_y += ln_step_y;
            end
            return 1'b1;
        end
        // end point reuses the previous pixel's color
        px = make_pixel(ln_end_x, ln_end_y, ln_shade, 1'b1);
        ln_busy = 1'b0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- s_ driver
    int s_gap  = 0;
    bit s_calm = 1'b0;

    always @(posedge aclk) begin
        pixel_t pix;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            // predict at the transfer edge, before the pixel can come back
            if (s_tvalid && s_tready) begin
                if (walk_pixel(cmd_on_bus, pix))
                    pixels_due.push_back(pix);
            end
            // an offered item that was not taken stays on the bus untouched
            if (!(s_tvalid && !s_tready)) begin
                if ($urandom_range(0, 99) == 0)
                    s_calm = !s_calm;
                if (s_gap == 0 && !no_idle && !s_calm && $urandom_range(0, 4) == 0)
                    s_gap = $urandom_range(1, 8);
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (line_cmds.size() != 0) begin
                    cmd_on_bus = line_cmds.pop_front();
                    s_tdata  <= {cmd_on_bus.to_color, cmd_on_bus.from_color,
                                 cmd_on_bus.to_y, cmd_on_bus.to_x,
                                 cmd_on_bus.from_y, cmd_on_bus.from_x};
                    s_tuser  <= cmd_on_bus.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- m_ monitor
    int m_gap  = 0;
    bit m_calm = 1'b0;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch("unexpected pixel", m_tdata, 0);
                end else begin
                    want = pixels_due.pop_front();
                    if (m_tdata[CW-1:0] !== want.x)
                        report_mismatch("pixel_x", m_tdata[CW-1:0], want.x);
                    if (m_tdata[2*CW-1:CW] !== want.y)
                        report_mismatch("pixel_y", m_tdata[2*CW-1:CW], want.y);
                    if (m_tdata[2*CW +: COLOR_BITS] !== want.color)
                        report_mismatch("pixel_color", m_tdata[2*CW +: COLOR_BITS], want.color);
                    if (m_tuser !== want.on_screen)
                        report_mismatch("on_screen", m_tuser, want.on_screen);
                    if (m_tlast !== want.last)
                        report_mismatch("last_pixel", m_tlast, want.last);
                end
            end
            // receiver stalls fall on any cycle, valid or not
            if ($urandom_range(0, 99) == 0)
                m_calm = !m_calm;
            if (m_gap == 0 && !no_idle && !m_calm && $urandom_range(0, 3) == 0)
                m_gap = $urandom_range(1, 8);
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers
    task automatic push_load(int fx, int fy, int tx, int ty,
                             logic [COLOR_BITS-1:0] fc, logic [COLOR_BITS-1:0] tc);
        line_cmd_t c;
        c.mode       = MODE_LOAD;
        c.from_x     = CW'(fx);
        c.from_y     = CW'(fy);
        c.to_x       = CW'(tx);
        c.to_y       = CW'(ty);
        c.from_color = fc;
        c.to_color   = tc;
        line_cmds.push_back(c);
    endtask

    // step payload is ignored by the block, so it carries random bits
    task automatic push_steps(int count);
        line_cmd_t c;
        for (int k = 0; k < count; k++) begin
            c.mode       = MODE_STEP;
            c.from_x     = CW'($urandom);
            c.from_y     = CW'($urandom);
            c.to_x       = CW'($urandom);
            c.to_y       = CW'($urandom);
            c.from_color = COLOR_BITS'($urandom);
            c.to_color   = COLOR_BITS'($urandom);
            line_cmds.push_back(c);
        end
    endtask

    function automatic int pick_coord(int lim);
        int v;
        case ($urandom_range(0, 3))
            0:       v = int'($urandom_range(0, 4095)) - 2048;
            1:       v = int'($urandom_range(0, 8)) - 4;
            2:       v = lim + int'($urandom_range(0, 8)) - 4;
            default: v = int'($urandom_range(0, lim));
        endcase
        return (v > 2047) ? 2047 : v;
    endfunction

    // end point inside the coordinate range
    function automatic int fit_end(int from, int delta);
        int t;
        t = from + delta;
        if (t > 2047 || t < -2048)
            t = from - delta;
        return t;
    endfunction

    function automatic logic [COLOR_BITS-1:0] pick_color();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
        return COLOR_BITS'($urandom);
    endfunction

    // one random line: mostly walked to the end, some cut short by the next
    // load, some with wild endpoints, a few lone steps
    task automatic queue_line(output int n);
        int kind, reach, fx, fy, tx, ty, dx, dy, len, steps;
        kind = $urandom_range(0, 99);
        if (kind >= 95) begin
            steps = $urandom_range(1, 3);
            push_steps(steps);
            n = steps;
        end else begin
            if (kind < 10) begin
                fx = int'($urandom_range(0, 4095)) - 2048;
                fy = int'($urandom_range(0, 4095)) - 2048;
                tx = int'($urandom_range(0, 4095)) - 2048;
                ty = int'($urandom_range(0, 4095)) - 2048;
                steps = $urandom_range(0, 3);
            end else begin
                reach = ($urandom_range(0, 39) == 0) ? 60 : 12;
                fx = pick_coord(scr_w);
                fy = pick_coord(scr_h);
                dx = int'($urandom_range(0, 2 * reach)) - reach;
                dy = int'($urandom_range(0, 2 * reach)) - reach;
                case ($urandom_range(0, 5))
                    0:       dy = 0;
                    1:       dx = 0;
                    2:       dy = ($urandom_range(0, 1) != 0) ? dx : -dx;
                    3:       begin dx = 0; dy = 0; end
                    default: ;
                endcase
                tx = fit_end(fx, dx);
                ty = fit_end(fy, dy);
                len = (iabs(tx - fx) > iabs(ty - fy)) ? iabs(tx - fx) : iabs(ty - fy);
                if (kind < 80)
                    steps = len + 1 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
                else
                    steps = $urandom_range(0, len);
            end
            push_load(fx, fy, tx, ty, pick_color(), pick_color());
            push_steps(steps);
            n = 1 + steps;
        end
    endtask

    task automatic write_reg(logic idx, int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= SCR_BITS'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            scr_w = value;
        else
            scr_h = value;
    endtask

    // block idle: nothing queued, nothing offered, no pixel outstanding
    task automatic wait_drained();
        do @(negedge aclk);
        while (line_cmds.size() != 0 || s_tvalid || pixels_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        int n, k, w, h;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, reset screen 1000 x 1000
        push_steps(1);                                            // no line loaded
        push_load(5, 5, 5, 5, 24'h123456, 24'hFFFFFF);            // zero-length line
        push_steps(2);                                            // second step finds it closed
        push_load(2047, -2048, -2048, 2047, 24'hFFFFFF, 24'h000000);
        push_steps(2);
        push_load(998, 997, 1001, 999, 24'h000000, 24'hFFFFFF);   // drops the line above
        push_steps(4);                                            // walks across the x edge
        push_load(0, -1, -2, 3, 24'hFF00FF, 24'h00FF00);          // y-major, negative x step
        push_steps(5);
        push_load(1, 1, 4, -2, 24'h0000FF, 24'hFF0000);           // diagonal
        push_steps(4);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0:       begin w = 640;  h = 480;  end
                1:       begin w = 2047; h = 2047; end
                2:       begin w = 1;    h = 2047; end
                3:       begin w = 2047; h = 1;    end
                4:       begin w = 0;    h = 0;    end   // nothing is on screen
                5:       begin w = $urandom_range(1, 2047); h = $urandom_range(1, 2047); end
                default: begin w = 1000; h = 1000; end
            endcase
            write_reg(REG_SCREEN_WIDTH, w);
            write_reg(REG_SCREEN_HEIGHT, h);
            @(negedge aclk);
            if (p == NUM_PHASES - 1)
                no_idle = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS) begin
                queue_line(k);
                n += k;
            end
            // close any open line before the next register write
            push_load(0, 0, 0, 0, 24'h000000, 24'h000000);
            push_steps(1);
        end
        wait_drained();

        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ gradient_line_rasterizer_top.f @@
rtl/glr_pkg.sv
rtl/glr_div.sv
rtl/glr_dp.sv
rtl/glr_ctrl.sv
rtl/gradient_line_rasterizer_top.sv
dv/tb_gradient_line_rasterizer_top.sv
